@@ src/ccm_pkg.sv @@
// ccm_pkg: shared types and constants of the call-charge meter.
// Used by ccm_pitch, call_charge_meter_core and the bench; no dependencies.
package ccm_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_UNIT_LENGTH    = 3'd0,
    CFG_MONEY_PER_UNIT = 3'd1,
    CFG_COSTS_LIMIT    = 3'd2,
    CFG_LIMIT_TYPE     = 3'd3,
    CFG_LIMIT_VALUE    = 3'd4,
    CFG_BEEP_ENABLE    = 3'd5
  } cfg_idx_e;

  // Limit kinds
  typedef enum logic [1:0] {
    LIM_SECONDS = 2'd0,
    LIM_MINUTES = 2'd1,
    LIM_HOURS   = 2'd2,
    LIM_UNITS   = 2'd3
  } limit_type_e;

  // Transaction kinds carried in tuser
  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  // Register reset values
  localparam logic [19:0] UNIT_LENGTH_RST = 20'd60;
  localparam logic [31:0] COSTS_LIMIT_RST = 32'hFFFF_FFFF;

  // Unit countdown saturation bounds (22-bit signed, held in 24 bits)
  localparam logic signed [23:0] REM_MIN = -24'sd2097152;
  localparam logic signed [23:0] REM_MAX = 24'sd2097151;

  // Beep: remaining count fits 14 bits for any tick rate up to 1024
  localparam int unsigned  BEEP_REM_W = 14;
  localparam logic [11:0]  PITCH_TOP  = 12'd4000;

  // Beep request handed from the counter stage to the pitch stage
  typedef struct packed {
    logic                  hit;
    logic [BEEP_REM_W-1:0] rem;
  } beep_req_t;

  // Result fields other than the pitch
  typedef struct packed {
    logic [39:0] elapsed_ticks;
    logic [31:0] money_spent;
    logic [31:0] units_used;
    logic        limit_reached;
    logic        cost_warning;
    logic        unit_passed;
    logic        time_advanced;
  } result_t;

endpackage

@@ src/ccm_pitch.sv @@
// ccm_pitch: registered beep pitch stage, 4000 - rem*300/TICKS_PER_SECOND.
// Depends on ccm_pkg. The division is a multiply by a rounded-up reciprocal.
module ccm_pitch #(
  parameter int unsigned TICKS_PER_SECOND = 1
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  ccm_pkg::beep_req_t req_i,
  output logic [11:0]       pitch_o
);

  // rem*300 width; reciprocal exact for every x below 2^XW
  localparam int unsigned     XW          = ccm_pkg::BEEP_REM_W + 9;
  localparam int unsigned     RecipShift  = XW + $clog2(TICKS_PER_SECOND);
  localparam longint unsigned RecipFull   =
    ((64'd1 << RecipShift) + TICKS_PER_SECOND - 1) / TICKS_PER_SECOND;
  localparam logic [XW:0]     Recip       = (XW+1)'(RecipFull);
  localparam int unsigned     PW          = 2 * XW + 1;

  logic [XW-1:0] scaled;
  logic [PW-1:0] prod;
  logic [11:0]   quot;
  logic [11:0]   pitch_d;
  logic [11:0]   pitch_q;

  // rem * 300 as shift-adds (300 = 256 + 32 + 8 + 4)
  always_comb begin
    scaled = (XW'(req_i.rem) << 8) + (XW'(req_i.rem) << 5)
           + (XW'(req_i.rem) << 3) + (XW'(req_i.rem) << 2);
  end

  // Divide by the tick rate through the reciprocal
  assign prod    = PW'(scaled) * PW'(Recip);
  assign quot    = 12'(prod >> RecipShift);
  assign pitch_d = req_i.hit ? (ccm_pkg::PITCH_TOP - quot) : 12'd0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pitch_q <= pitch_d;
    end
  end

  assign pitch_o = pitch_q;

endmodule

@@ src/call_charge_meter_core.sv @@
// call_charge_meter_core: per-second call-charge meter, top level.
// Depends on ccm_pkg and ccm_pitch.
//
// Takes one transaction per clock on the slave stream while a stage is free
// and returns one result per transaction through a two-stage pipeline: the
// first stage updates the connection counters (delay, units, money, ticks,
// limit counter) and the second turns the end-of-unit countdown into a beep
// pitch with one reciprocal multiply. The sustained rate is one item per
// cycle while the master side takes results; a result passes the first and
// then the second stage register. A stalled master side stalls the pipeline.
// The scaled limit is precomputed in a register whenever the limit registers
// are written. Configuration writes take effect at once and are only meant
// to happen while no transaction is in flight.
module call_charge_meter_core #(
  parameter int unsigned TICKS_PER_SECOND = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // [15:0] start_delay, [16] start_suspended
  input  logic [0:0]   s_axis_tuser,   // [0] mode
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] time_advanced, [1] unit_passed, [2] cost_warning, [3] limit_reached,
  // [15:4] beep_pitch, [47:16] units_used, [79:48] money_spent,
  // [119:80] elapsed_ticks
  output logic [119:0] m_axis_tdata
);

  localparam int unsigned BeepMax  = 10 * TICKS_PER_SECOND;
  localparam logic [21:0] FacSec   = 22'(TICKS_PER_SECOND);
  localparam logic [21:0] FacMin   = 22'(TICKS_PER_SECOND * 60);
  localparam logic [21:0] FacHour  = 22'(TICKS_PER_SECOND * 3600);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [19:0] unit_length_q, unit_length_d;
  logic [15:0] money_per_unit_q, money_per_unit_d;
  logic [31:0] costs_limit_q, costs_limit_d;
  logic [1:0]  limit_type_q, limit_type_d;
  logic [15:0] limit_value_q, limit_value_d;
  logic        beep_enable_q, beep_enable_d;
  logic [39:0] lim_q, lim_d;
  logic [21:0] lim_factor;
  logic [37:0] lim_prod;

  always_comb begin
    unit_length_d    = unit_length_q;
    money_per_unit_d = money_per_unit_q;
    costs_limit_d    = costs_limit_q;
    limit_type_d     = limit_type_q;
    limit_value_d    = limit_value_q;
    beep_enable_d    = beep_enable_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ccm_pkg::CFG_UNIT_LENGTH:    unit_length_d    = cfg_data_i[19:0];
        ccm_pkg::CFG_MONEY_PER_UNIT: money_per_unit_d = cfg_data_i[15:0];
        ccm_pkg::CFG_COSTS_LIMIT:    costs_limit_d    = cfg_data_i;
        ccm_pkg::CFG_LIMIT_TYPE:     limit_type_d     = cfg_data_i[1:0];
        ccm_pkg::CFG_LIMIT_VALUE:    limit_value_d    = cfg_data_i[15:0];
        ccm_pkg::CFG_BEEP_ENABLE:    beep_enable_d    = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Scaled limit follows the register values that take effect this edge
  always_comb begin
    unique case (limit_type_d)
      ccm_pkg::LIM_SECONDS: lim_factor = FacSec;
      ccm_pkg::LIM_MINUTES: lim_factor = FacMin;
      ccm_pkg::LIM_HOURS:   lim_factor = FacHour;
      default:              lim_factor = 22'd1;
    endcase
  end

  assign lim_prod = 38'(limit_value_d) * 38'(lim_factor);
  assign lim_d    = 40'(lim_prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_length_q    <= ccm_pkg::UNIT_LENGTH_RST;
      money_per_unit_q <= 16'd0;
      costs_limit_q    <= ccm_pkg::COSTS_LIMIT_RST;
      limit_type_q     <= 2'd0;
      limit_value_q    <= 16'd0;
      beep_enable_q    <= 1'b0;
      lim_q            <= 40'd0;
    end else begin
      unit_length_q    <= unit_length_d;
      money_per_unit_q <= money_per_unit_d;
      costs_limit_q    <= costs_limit_d;
      limit_type_q     <= limit_type_d;
      limit_value_q    <= limit_value_d;
      beep_enable_q    <= beep_enable_d;
      lim_q            <= lim_d;
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline handshake
  // ---------------------------------------------------------------------
  logic v1_q, v2_q;
  logic s1_ready, s2_ready;
  logic acc;
  logic mode;

  assign s2_ready      = !v2_q || m_axis_tready;
  assign s1_ready      = !v1_q || s2_ready;
  assign s_axis_tready = s1_ready;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign mode          = s_axis_tuser[0];

  // ---------------------------------------------------------------------
  // Connection state
  // ---------------------------------------------------------------------
  logic [15:0] delay_q, delay_d;
  logic        susp_q, susp_d;
  logic [39:0] tick_q, tick_d;
  logic [21:0] urem_q, urem_d;
  logic [31:0] units_q, units_d;
  logic [31:0] money_q, money_d;
  logic        warned_q, warned_d;
  logic [39:0] lp_q, lp_d;

  logic               counting, susp_eff, advance;
  logic               passed, warn_hit, type_units, do_lp, reached;
  logic signed [23:0] rem_s, rem_wrap, rem_fin, rem_sat;
  logic [40:0]        tick_sum, lp_sum, lp_inc;
  logic [32:0]        units_sum, money_sum;
  logic [31:0]        money_new;
  logic [39:0]        lp_new;
  logic               beep_hit;

  ccm_pkg::result_t   res1_d;
  ccm_pkg::beep_req_t beep1_d;

  // Tick arithmetic, all from the current state
  always_comb begin
    counting   = (delay_q == 16'd0) || (delay_q == 16'd1);
    susp_eff   = (delay_q == 16'd1) ? 1'b0 : susp_q;
    advance    = counting && !susp_eff;
    type_units = (limit_type_q == ccm_pkg::LIM_UNITS);

    rem_s    = $signed({{2{urem_q[21]}}, urem_q}) - $signed(24'(TICKS_PER_SECOND));
    rem_wrap = rem_s + $signed({4'd0, unit_length_q});
    passed   = (rem_s <= 24'sd0);
    rem_fin  = passed ? rem_wrap : rem_s;
    if (rem_fin < ccm_pkg::REM_MIN) begin
      rem_sat = ccm_pkg::REM_MIN;
    end else if (rem_fin > ccm_pkg::REM_MAX) begin
      rem_sat = ccm_pkg::REM_MAX;
    end else begin
      rem_sat = rem_fin;
    end
    beep_hit = !passed && beep_enable_q && (rem_s <= $signed(24'(BeepMax)));

    tick_sum  = {1'b0, tick_q} + 41'(TICKS_PER_SECOND);
    units_sum = {1'b0, units_q} + 33'd1;
    money_sum = {1'b0, money_q} + 33'(money_per_unit_q);
    money_new = money_sum[32] ? 32'hFFFF_FFFF : money_sum[31:0];
    warn_hit  = passed && (money_new >= costs_limit_q) && !warned_q;

    lp_inc  = type_units ? 41'd1 : 41'(TICKS_PER_SECOND);
    lp_sum  = {1'b0, lp_q} + lp_inc;
    lp_new  = lp_sum[40] ? 40'hFF_FFFF_FFFF : lp_sum[39:0];
    do_lp   = advance && (!type_units || passed);
    reached = do_lp && (lim_q != 40'd0) && (lp_new == lim_q);
  end

  // Next state and first-stage result
  always_comb begin
    delay_d  = delay_q;
    susp_d   = susp_q;
    tick_d   = tick_q;
    urem_d   = urem_q;
    units_d  = units_q;
    money_d  = money_q;
    warned_d = warned_q;
    lp_d     = lp_q;
    res1_d   = '0;
    beep1_d  = '0;
    if (acc) begin
      if (mode == ccm_pkg::MODE_RESTART) begin
        // restart transaction
        delay_d  = s_axis_tdata[15:0];
        susp_d   = s_axis_tdata[16];
        tick_d   = 40'd0;
        urem_d   = {2'b00, unit_length_q};
        units_d  = 32'd1;
        money_d  = 32'(money_per_unit_q);
        warned_d = 1'b0;
        lp_d     = 40'd0;
      end else begin
        // tick transaction
        if (delay_q != 16'd0) begin
          delay_d = delay_q - 16'd1;
        end
        susp_d = susp_eff;
        if (advance) begin
          tick_d = tick_sum[40] ? 40'hFF_FFFF_FFFF : tick_sum[39:0];
          urem_d = 22'(rem_sat);
          if (passed) begin
            units_d = units_sum[32] ? 32'hFFFF_FFFF : units_sum[31:0];
            money_d = money_new;
          end
          if (warn_hit) begin
            warned_d = 1'b1;
          end
          if (do_lp) begin
            lp_d = lp_new;
          end
          res1_d.time_advanced = 1'b1;
          res1_d.unit_passed   = passed;
          res1_d.cost_warning  = warn_hit;
          res1_d.limit_reached = reached;
          beep1_d.hit          = beep_hit;
          beep1_d.rem          = rem_s[ccm_pkg::BEEP_REM_W-1:0];
        end
      end
      res1_d.units_used    = units_d;
      res1_d.money_spent   = money_d;
      res1_d.elapsed_ticks = tick_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= 16'd0;
      susp_q   <= 1'b0;
      tick_q   <= 40'd0;
      urem_q   <= {2'b00, ccm_pkg::UNIT_LENGTH_RST};
      units_q  <= 32'd1;
      money_q  <= 32'd0;
      warned_q <= 1'b0;
      lp_q     <= 40'd0;
    end else begin
      delay_q  <= delay_d;
      susp_q   <= susp_d;
      tick_q   <= tick_d;
      urem_q   <= urem_d;
      units_q  <= units_d;
      money_q  <= money_d;
      warned_q <= warned_d;
      lp_q     <= lp_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage registers
  // ---------------------------------------------------------------------
  ccm_pkg::result_t   res1_q, res2_q;
  ccm_pkg::beep_req_t beep1_q;
  logic [11:0]        pitch2;
  logic               s2_load;

  assign s2_load = v1_q && s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        v1_q <= acc;
      end
      if (s2_ready) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res1_q  <= res1_d;
      beep1_q <= beep1_d;
    end
    if (s2_load) begin
      res2_q <= res1_q;
    end
  end

  // Beep pitch, registered alongside the second stage
  ccm_pitch #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_pitch (
    .clk_i  (clk_i),
    .en_i   (s2_load),
    .req_i  (beep1_q),
    .pitch_o(pitch2)
  );

  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = {res2_q.elapsed_ticks, res2_q.money_spent, res2_q.units_used,
                          pitch2, res2_q.limit_reached, res2_q.cost_warning,
                          res2_q.unit_passed, res2_q.time_advanced};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Slave side only stalls when both stages hold a transaction
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && v2_q))
    else $error("input stalled with a free pipeline stage");

  // A new unit is only reported on a counted tick
  a_unit_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[0])
    else $error("unit passed without time advance");

  // Beep only on a counted tick that did not start a unit
  a_beep_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[15:4] != 12'd0)) |->
      (m_axis_tdata[0] && !m_axis_tdata[1]))
    else $error("beep pitch on a wrong tick");

  // Cost warning arms the one-shot flag
  a_warn_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (mode == ccm_pkg::MODE_TICK) && advance && warn_hit) |=> warned_q)
    else $error("cost warning did not latch");

  // Elapsed time never goes back on a tick
  a_tick_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (mode == ccm_pkg::MODE_TICK)) |=> (tick_q >= $past(tick_q)))
    else $error("elapsed ticks decreased");

endmodule

@@ tb/sv/call_charge_meter_core_tb.sv @@
// call_charge_meter_core_tb: self-checking bench for the call-charge meter core.
// Drives restart and tick transactions against an in-bench meter predictor.
// Depends on ccm_pkg and call_charge_meter_core.
`timescale 1ns / 100ps

module call_charge_meter_core_tb;

  localparam int unsigned TPS            = 1;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          SETTLE_CYCLES  = 6;
  localparam int          SEGMENT_ITEMS  = 270;
  localparam int          LIMIT_TICKS    = 40;
  localparam longint      REM_LOW        = -2097152;
  localparam longint      REM_HIGH       = 2097151;
  localparam longint unsigned MAX32      = 64'hFFFF_FFFF;
  localparam longint unsigned MAX40      = 64'hFF_FFFF_FFFF;

  // one meter reading, packed as on m_axis_tdata
  typedef struct packed {
    logic [39:0] elapsed;
    logic [31:0] money;
    logic [31:0] units;
    logic [11:0] pitch;
    logic        reached;
    logic        warn;
    logic        passed;
    logic        advanced;
  } meter_reading_t;

  typedef struct packed {
    logic           mode;
    logic [15:0]    delay;
    logic           susp;
    logic           typed;
    meter_reading_t want;
  } stim_row_t;

  // DUT ports
  logic         clk_i;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic [2:0]   cfg_idx_i     = '0;
  logic [31:0]  cfg_data_i    = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata  = '0;  // [15:0] start_delay, [16] start_suspended
  logic [0:0]   s_axis_tuser  = '0;  // [0] mode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;        // time_advanced .. elapsed_ticks, lowest first

  // predictor: register copy
  logic [19:0]          m_unit_len   = ccm_pkg::UNIT_LENGTH_RST;
  logic [15:0]          m_price      = '0;
  logic [31:0]          m_cost_limit = ccm_pkg::COSTS_LIMIT_RST;
  ccm_pkg::limit_type_e m_lim_type   = ccm_pkg::LIM_SECONDS;
  logic [15:0]          m_lim_value  = '0;
  logic                 m_beep       = 1'b0;

  // predictor: connection state
  logic [15:0]        m_delay;
  logic               m_susp;
  logic [39:0]        m_ticks;
  logic signed [23:0] m_remain;
  logic [31:0]        m_units;
  logic [31:0]        m_money;
  logic               m_warned;
  logic [39:0]        m_progress;

  meter_reading_t reading_q[$];
  stim_row_t      directed_rows[$];
  int             mismatch_cnt  = 0;
  int             idle_cycles   = 0;
  int             src_idle_pct  = 0;
  int             snk_stall_pct = 0;

  call_charge_meter_core #(
    .TICKS_PER_SECOND(TPS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint unsigned clamp_sum(input longint unsigned a,
                                                input longint unsigned b,
                                                input longint unsigned ceiling);
    longint unsigned s;
    s = a + b;
    return (s > ceiling) ? ceiling : s;
  endfunction

  // fresh connection: used at reset and on every restart transaction
  function automatic void open_connection(input logic [15:0] dly, input logic sp);
    m_delay    = dly;
    m_susp     = sp;
    m_ticks    = '0;
    m_remain   = signed'({4'd0, m_unit_len});
    m_units    = 32'd1;
    m_money    = 32'(m_price);
    m_warned   = 1'b0;
    m_progress = '0;
  endfunction

  // next meter reading for one accepted transaction
  function automatic meter_reading_t meter_advance(input logic md, input logic [15:0] dly,
                                                   input logic sp);
    meter_reading_t r;
    logic            counted;
    longint unsigned lim;
    longint          rem;
    r = '0;
    if (md == ccm_pkg::MODE_RESTART) begin
      open_connection(dly, sp);
    end else begin
      counted = 1'b1;
      // start delay runs first; the tick that ends it resumes and counts
      if (m_delay != 0) begin
        m_delay = m_delay - 16'd1;
        if (m_delay != 0) counted = 1'b0;
        else m_susp = 1'b0;
      end
      if (counted && !m_susp) begin
        case (m_lim_type)
          ccm_pkg::LIM_SECONDS: lim = longint'(m_lim_value) * TPS;
          ccm_pkg::LIM_MINUTES: lim = longint'(m_lim_value) * TPS * 60;
          ccm_pkg::LIM_HOURS:   lim = longint'(m_lim_value) * TPS * 3600;
          default:              lim = longint'(m_lim_value);
        endcase
        r.advanced = 1'b1;
        m_ticks = 40'(clamp_sum(m_ticks, TPS, MAX40));
        rem = longint'(m_remain) - longint'(TPS);
        if (rem <= 0) begin
          // new unit: at most one per tick
          rem = rem + longint'(m_unit_len);
          m_units = 32'(clamp_sum(m_units, 1, MAX32));
          m_money = 32'(clamp_sum(m_money, m_price, MAX32));
          r.passed = 1'b1;
          if (m_money >= m_cost_limit && !m_warned) begin
            m_warned = 1'b1;
            r.warn   = 1'b1;
          end
          if (m_lim_type == ccm_pkg::LIM_UNITS) begin
            m_progress = 40'(clamp_sum(m_progress, 1, MAX40));
            if (lim != 0 && m_progress == lim) r.reached = 1'b1;
          end
        end else if (rem <= 10 * TPS && m_beep) begin
          r.pitch = 12'(4000 - (rem * 300) / TPS);
        end
        if (rem < REM_LOW) rem = REM_LOW;
        if (rem > REM_HIGH) rem = REM_HIGH;
        m_remain = 24'(rem);
        if (m_lim_type != ccm_pkg::LIM_UNITS) begin
          m_progress = 40'(clamp_sum(m_progress, TPS, MAX40));
          if (lim != 0 && m_progress == lim) r.reached = 1'b1;
        end
      end
    end
    r.units   = m_units;
    r.money   = m_money;
    r.elapsed = m_ticks;
    return r;
  endfunction

  function automatic meter_reading_t outcome(input int adv, input int passed,
                                             input int warn, input int reached,
                                             input int pitch,
                                             input longint unsigned units,
                                             input longint unsigned money,
                                             input longint unsigned elapsed);
    meter_reading_t r;
    r.advanced = 1'(adv);
    r.passed   = 1'(passed);
    r.warn     = 1'(warn);
    r.reached  = 1'(reached);
    r.pitch    = 12'(pitch);
    r.units    = 32'(units);
    r.money    = 32'(money);
    r.elapsed  = 40'(elapsed);
    return r;
  endfunction

  task automatic add_row(input logic md, input logic [15:0] dly, input logic sp,
                         input logic typed, input meter_reading_t want);
    stim_row_t row;
    row.mode  = md;
    row.delay = dly;
    row.susp  = sp;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // offer one transaction; the predictor runs at the accepting edge
  task automatic offer_item(input logic md, input logic [15:0] dly, input logic sp,
                            input logic typed, input meter_reading_t preset);
    meter_reading_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, sp, dly};
    s_axis_tuser  <= md;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = meter_advance(md, dly, sp);
    reading_q.push_back(typed ? preset : pred);
  endtask

  // stop sending and wait until every reading is back and the pipe is empty
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (reading_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write all six registers, one per edge; block must be idle
  task automatic load_settings(input logic [19:0] ul, input logic [15:0] mpu,
                               input logic [31:0] cl, input ccm_pkg::limit_type_e lt,
                               input logic [15:0] lv, input logic be);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= ccm_pkg::CFG_UNIT_LENGTH;
    cfg_data_i <= 32'(ul);
    @(posedge clk_i);
    cfg_idx_i  <= ccm_pkg::CFG_MONEY_PER_UNIT;
    cfg_data_i <= 32'(mpu);
    @(posedge clk_i);
    cfg_idx_i  <= ccm_pkg::CFG_COSTS_LIMIT;
    cfg_data_i <= cl;
    @(posedge clk_i);
    cfg_idx_i  <= ccm_pkg::CFG_LIMIT_TYPE;
    cfg_data_i <= 32'(lt);
    @(posedge clk_i);
    cfg_idx_i  <= ccm_pkg::CFG_LIMIT_VALUE;
    cfg_data_i <= 32'(lv);
    @(posedge clk_i);
    cfg_idx_i  <= ccm_pkg::CFG_BEEP_ENABLE;
    cfg_data_i <= 32'(be);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    m_unit_len   = ul;
    m_price      = mpu;
    m_cost_limit = cl;
    m_lim_type   = lt;
    m_lim_value  = lv;
    m_beep       = be;
  endtask

  // random traffic: mostly ticks, occasional restarts, mostly with short delays
  task automatic run_traffic(input int count);
    logic        md;
    logic [15:0] dly;
    logic        sp;
    int          pick;
    for (int k = 0; k < count; k++) begin
      md   = ($urandom_range(99) < 6) ? ccm_pkg::MODE_RESTART : ccm_pkg::MODE_TICK;
      pick = $urandom_range(99);
      if (md == ccm_pkg::MODE_RESTART && pick < 70) dly = 16'($urandom_range(4));
      else if (md == ccm_pkg::MODE_RESTART && pick < 90) dly = 16'($urandom_range(60));
      else dly = 16'($urandom);
      sp = 1'($urandom);
      offer_item(md, dly, sp, 1'b0, '0);
    end
  endtask

  task automatic check_field(input string tag, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatch_cnt++;
      $display("%0t: %s expected %0d, actual %0d", $time, tag, want, got);
    end
  endtask

  // result side: random stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // compare each result transaction with the oldest pending reading
  always @(posedge clk_i) begin
    meter_reading_t got;
    meter_reading_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (reading_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
        want = reading_q.pop_front();
        check_field("time_advanced", want.advanced, got.advanced);
        check_field("unit_passed", want.passed, got.passed);
        check_field("cost_warning", want.warn, got.warn);
        check_field("limit_reached", want.reached, got.reached);
        check_field("beep_pitch", want.pitch, got.pitch);
        check_field("units_used", want.units, got.units);
        check_field("money_spent", want.money, got.money);
        check_field("elapsed_ticks", want.elapsed, got.elapsed);
      end
    end
  end

  // watchdog: too long without any transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    open_connection(16'd0, 1'b0);

    // unit of 12, price 100, warning at 200, limit 3 seconds, beep on
    add_row(ccm_pkg::MODE_RESTART, 16'd0, 1'b0, 1'b1, outcome(0, 0, 0, 0, 0, 1, 100, 0));
    add_row(ccm_pkg::MODE_TICK, 16'd0, 1'b0, 1'b1, outcome(1, 0, 0, 0, 0, 1, 100, 1));
    add_row(ccm_pkg::MODE_TICK, 16'd0, 1'b0, 1'b1, outcome(1, 0, 0, 0, 1000, 1, 100, 2));
    add_row(ccm_pkg::MODE_TICK, 16'd0, 1'b0, 1'b1, outcome(1, 0, 0, 1, 1300, 1, 100, 3));
    repeat (8) add_row(ccm_pkg::MODE_TICK, 16'hFFFF, 1'b1, 1'b0, '0);
    // countdown hits zero: new unit, money reaches the warning level
    add_row(ccm_pkg::MODE_TICK, 16'd0, 1'b0, 1'b0, '0);
    // start delay of three, suspended until it runs out
    add_row(ccm_pkg::MODE_RESTART, 16'd3, 1'b1, 1'b1, outcome(0, 0, 0, 0, 0, 1, 100, 0));
    add_row(ccm_pkg::MODE_TICK, 16'd0, 1'b0, 1'b1, outcome(0, 0, 0, 0, 0, 1, 100, 0));
    add_row(ccm_pkg::MODE_TICK, 16'd0, 1'b0, 1'b1, outcome(0, 0, 0, 0, 0, 1, 100, 0));
    add_row(ccm_pkg::MODE_TICK, 16'd0, 1'b0, 1'b0, '0);
    // suspended with no delay: ticks are not counted
    add_row(ccm_pkg::MODE_RESTART, 16'd0, 1'b1, 1'b1, outcome(0, 0, 0, 0, 0, 1, 100, 0));
    add_row(ccm_pkg::MODE_TICK, 16'd0, 1'b0, 1'b1, outcome(0, 0, 0, 0, 0, 1, 100, 0));
    // longest delay
    add_row(ccm_pkg::MODE_RESTART, 16'hFFFF, 1'b0, 1'b1, outcome(0, 0, 0, 0, 0, 1, 100, 0));
    add_row(ccm_pkg::MODE_TICK, 16'd0, 1'b0, 1'b1, outcome(0, 0, 0, 0, 0, 1, 100, 0));
    // delay of one resumes on the first tick
    add_row(ccm_pkg::MODE_RESTART, 16'd1, 1'b1, 1'b1, outcome(0, 0, 0, 0, 0, 1, 100, 0));
    add_row(ccm_pkg::MODE_TICK, 16'd0, 1'b0, 1'b0, '0);
    add_row(ccm_pkg::MODE_TICK, 16'd0, 1'b0, 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles a little, receiver a lot
    src_idle_pct  = 9;
    snk_stall_pct = 72;
    load_settings(20'd12, 16'd100, 32'd200, ccm_pkg::LIM_SECONDS, 16'd3, 1'b1);
    foreach (directed_rows[i])
      offer_item(directed_rows[i].mode, directed_rows[i].delay, directed_rows[i].susp,
                 directed_rows[i].typed, directed_rows[i].want);
    settle_idle();
    load_settings(20'd7, 16'd13, 32'd100, ccm_pkg::LIM_UNITS, 16'd5, 1'b1);
    run_traffic(SEGMENT_ITEMS);
    settle_idle();
    load_settings(20'd1, 16'hFFFF, 32'hFFFF_FFFF, ccm_pkg::LIM_SECONDS, 16'hFFFF, 1'b1);
    run_traffic(SEGMENT_ITEMS);
    settle_idle();

    // sender idles a lot, receiver a little
    src_idle_pct  = 72;
    snk_stall_pct = 9;
    load_settings(20'hF_FFFF, 16'd0, 32'd0, ccm_pkg::LIM_MINUTES, 16'd1, 1'b1);
    run_traffic(SEGMENT_ITEMS);
    settle_idle();
    load_settings(20'd0, 16'd1, 32'd50, ccm_pkg::LIM_HOURS, 16'd0, 1'b0);
    run_traffic(SEGMENT_ITEMS);
    settle_idle();

    // full rate both ways
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    load_settings(20'd11, 16'd40000, 32'h7FFF_FFFF, ccm_pkg::LIM_UNITS, 16'hFFFF, 1'b1);
    run_traffic(SEGMENT_ITEMS);
    settle_idle();
    load_settings(20'($urandom_range(1, 40)), 16'($urandom), 32'($urandom),
                  ccm_pkg::limit_type_e'($urandom_range(3)), 16'($urandom_range(40)),
                  1'($urandom));
    run_traffic(SEGMENT_ITEMS);
    settle_idle();

    // one unit per tick at top price: cost warning, then the unit limit fires
    load_settings(20'd1, 16'hFFFF, 32'd1000000, ccm_pkg::LIM_UNITS, 16'd30, 1'b0);
    offer_item(ccm_pkg::MODE_RESTART, 16'd0, 1'b0, 1'b0, '0);
    for (int k = 0; k < LIMIT_TICKS; k++)
      offer_item(ccm_pkg::MODE_TICK, 16'($urandom), 1'($urandom), 1'b0, '0);
    settle_idle();

    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/ccm_pkg.sv
src/ccm_pitch.sv
src/call_charge_meter_core.sv
tb/sv/call_charge_meter_core_tb.sv
